### hw/rtl/bdhr_pkg.sv
`default_nettype none
package bdhr_pkg;

  localparam int LANES     = 4;
  localparam int HIST_BITS = 5;
  localparam int HOLD_W    = 9;
  localparam int TIMER_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 1'b1;

  localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RST = 8'd100;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST  = 8'd25;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HELD     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] hold_threshold;
    logic [CFG_W-1:0] repeat_period;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/bdhr_in_if.sv
`default_nettype none
interface bdhr_in_if;
  logic                             valid;
  logic                             ready;
  logic [bdhr_pkg::OP_W-1:0]        operation;
  logic [bdhr_pkg::LANES-1:0]       raw_samples;
  logic [bdhr_pkg::LANES-1:0]       lane_mask;

  modport source (output valid, output operation, output raw_samples, output lane_mask,
                  input ready);
  modport sink   (input valid, input operation, input raw_samples, input lane_mask,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/bdhr_out_if.sv
`default_nettype none
interface bdhr_out_if;
  logic                             valid;
  logic                             ready;
  logic [2*bdhr_pkg::LANES-1:0]     lane_states;
  logic [bdhr_pkg::LANES-1:0]       event_flags;

  modport source (output valid, output lane_states, output event_flags, input ready);
  modport sink   (input valid, input lane_states, input event_flags, output ready);
endinterface
`default_nettype wire

### hw/rtl/button_debounce_hold_repeat_core.sv
// Debouncer for four active-low push buttons with hold detection and auto-repeat.
// The input channel carries one operation per transfer: a sample tick with one raw
// level per button, a clear of the event flags of the masked lanes, or a reset of
// the masked lanes; the unused fourth code changes no lane. Each accepted transfer
// yields exactly one result transfer with the phase of every lane and the latched
// event flags, as they stand after the operation.
// A transfer is held in an input register, then the lane logic updates the lane
// registers, which also serve as the result register. One transfer per cycle is
// sustained while the receiver keeps ready high; the rate is set by the single lane
// update stage.
// When the receiver stalls, the result holds, the pending input stays in the input
// register, and ready drops once both registers are occupied.
// The configuration port writes the hold threshold and the repeat period; writes
// are registered and should occur only while the block is idle.
// Reset is synchronous: all lanes return to released with full high history and
// zero counters, the registers return to 100 and 25, and both channels go empty.
`default_nettype none
module button_debounce_hold_repeat_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bdhr_in_if.sink                             in_ch,
  bdhr_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdhr_pkg::CFG_W-1:0]     cfg_wdata
);
  import bdhr_pkg::*;

  cfg_t             cfg;
  logic             in_valid_r;
  logic [OP_W-1:0]  op_r;
  logic [LANES-1:0] raw_r;
  logic [LANES-1:0] mask_r;
  logic             out_valid_r, out_valid_nxt;
  logic             advance;
  phase_t           phase [LANES];
  logic [LANES-1:0] events;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= in_ch.operation;
      raw_r  <= in_ch.raw_samples;
      mask_r <= in_ch.lane_mask;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  bdhr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bdhr_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (advance),
      .operation  (op_r),
      .sample     (raw_r[i]),
      .mask       (mask_r[i]),
      .cfg        (cfg),
      .phase      (phase[i]),
      .event_flag (events[i])
    );
    assign out_ch.lane_states[2*i +: 2] = phase[i];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_flags = events;

endmodule
`default_nettype wire

### hw/rtl/bdhr_cfg_regs.sv
`default_nettype none
module bdhr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdhr_pkg::CFG_W-1:0]     cfg_wdata,
  output bdhr_pkg::cfg_t                      cfg
);
  import bdhr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_THRESHOLD: cfg_nxt.hold_threshold = cfg_wdata;
        CFG_REPEAT_PERIOD:  cfg_nxt.repeat_period  = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_threshold <= HOLD_THRESHOLD_RST;
      cfg_r.repeat_period  <= REPEAT_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/bdhr_lane.sv
`default_nettype none
module bdhr_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [bdhr_pkg::OP_W-1:0] operation,
  input  wire logic                      sample,
  input  wire logic                      mask,
  input  bdhr_pkg::cfg_t                 cfg,
  output bdhr_pkg::phase_t               phase,
  output logic                           event_flag
);
  import bdhr_pkg::*;

  localparam logic [HIST_BITS-1:0] HIST_ONES = {HIST_BITS{1'b1}};
  localparam logic [HIST_BITS-1:0] HIST_ZERO = '0;
  localparam logic [HOLD_W-1:0]    HOLD_MAX  = {HOLD_W{1'b1}};

  phase_t               phase_r, phase_nxt;
  logic [HIST_BITS-1:0] hist_r, hist_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic                 event_r, event_nxt;
  logic [HIST_BITS-1:0] h;

  always_comb begin
    phase_nxt = phase_r;
    hist_nxt  = hist_r;
    hold_nxt  = hold_r;
    timer_nxt = timer_r;
    event_nxt = event_r;
    h         = hist_r;
    case (operation)
      OP_TICK: begin
        if (phase_r == PH_RELEASED) begin
          h = {hist_r[HIST_BITS-1:1], hist_r[0] & sample};
          if (h == HIST_ZERO) begin
            hist_nxt  = h;
            phase_nxt = PH_PRESSED;
            event_nxt = 1'b1;
          end else begin
            hist_nxt = {h[HIST_BITS-2:0], 1'b1};
          end
        end else begin
          h = {hist_r[HIST_BITS-1:1], hist_r[0] | sample};
          if (phase_r != PH_HELD && h == HIST_ZERO) begin
            if (hold_r >= {1'b0, cfg.hold_threshold}) begin
              phase_nxt = PH_HELD;
            end
            if (hold_r != HOLD_MAX) begin
              hold_nxt = hold_r + 1'b1;
            end
          end
          if (h == HIST_ONES) begin
            hist_nxt  = h;
            phase_nxt = PH_RELEASED;
            hold_nxt  = '0;
          end else begin
            hist_nxt = {h[HIST_BITS-2:0], 1'b0};
            if (phase_nxt == PH_HELD) begin
              if (timer_r == cfg.repeat_period) begin
                event_nxt = 1'b1;
                timer_nxt = '0;
              end else begin
                timer_nxt = timer_r + 1'b1;
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        if (mask) begin
          event_nxt = 1'b0;
        end
      end
      OP_RESET: begin
        if (mask) begin
          phase_nxt = PH_RELEASED;
          hist_nxt  = HIST_ONES;
          hold_nxt  = '0;
          timer_nxt = '0;
          event_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      hist_r  <= HIST_ONES;
      hold_r  <= '0;
      timer_r <= '0;
      event_r <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      hist_r  <= hist_nxt;
      hold_r  <= hold_nxt;
      timer_r <= timer_nxt;
      event_r <= event_nxt;
    end
  end

  assign phase      = phase_r;
  assign event_flag = event_r;

endmodule
`default_nettype wire

### dv/bdhr_lane_checker.sv
`timescale 1ns / 100ps
module bdhr_lane_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bdhr_in_if                                  in_ch,
  bdhr_out_if                                 out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdhr_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_checked,
  output int                                  held_results,
  output int                                  event_rises
);
  import bdhr_pkg::*;

  typedef struct packed {
    logic [2*LANES-1:0] states;
    logic [LANES-1:0]   flags;
  } lane_view_t;

  lane_view_t expected_views[$];

  cfg_t                 cfg_q;
  phase_t               phase_q[LANES];
  logic [HIST_BITS-1:0] hist_q[LANES];
  logic [HOLD_W-1:0]    hold_q[LANES];
  logic [TIMER_W-1:0]   timer_q[LANES];
  logic                 evt_q[LANES];

  int fail_tally;
  int checked_tally;
  int held_tally;
  int rise_tally;

  task automatic clear_lane(input int i);
    phase_q[i] = PH_RELEASED;
    hist_q[i]  = '1;
    hold_q[i]  = '0;
    timer_q[i] = '0;
    evt_q[i]   = 1'b0;
  endtask

  task automatic advance_lane(input int i, input logic level);
    logic [HIST_BITS-1:0] h;
    h = hist_q[i];
    if (phase_q[i] == PH_RELEASED) begin
      if (!level) h[0] = 1'b0;
      if (h == '0) begin
        hist_q[i]  = h;
        phase_q[i] = PH_PRESSED;
        evt_q[i]   = 1'b1;
      end else begin
        hist_q[i] = {h[HIST_BITS-2:0], 1'b1};
      end
    end else begin
      h[0] = h[0] | level;
      if (phase_q[i] != PH_HELD && h == '0) begin
        if (hold_q[i] >= HOLD_W'(cfg_q.hold_threshold)) phase_q[i] = PH_HELD;
        if (hold_q[i] != '1) hold_q[i] = hold_q[i] + 1'b1;
      end
      if (h == '1) begin
        hist_q[i]  = h;
        phase_q[i] = PH_RELEASED;
        hold_q[i]  = '0;
      end else begin
        hist_q[i] = {h[HIST_BITS-2:0], 1'b0};
        if (phase_q[i] == PH_HELD) begin
          if (timer_q[i] == TIMER_W'(cfg_q.repeat_period)) begin
            evt_q[i]   = 1'b1;
            timer_q[i] = '0;
          end else begin
            timer_q[i] = timer_q[i] + 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    lane_view_t view;
    lane_view_t got;
    logic       was_set;
    if (!rst_n) begin
      cfg_q.hold_threshold = HOLD_THRESHOLD_RST;
      cfg_q.repeat_period  = REPEAT_PERIOD_RST;
      for (int i = 0; i < LANES; i++) clear_lane(i);
      expected_views.delete();
      fail_tally    = 0;
      checked_tally = 0;
      held_tally    = 0;
      rise_tally    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLD_THRESHOLD: cfg_q.hold_threshold = cfg_wdata;
          CFG_REPEAT_PERIOD:  cfg_q.repeat_period  = cfg_wdata;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        for (int i = 0; i < LANES; i++) begin
          was_set = evt_q[i];
          case (in_ch.operation)
            OP_TICK:  advance_lane(i, in_ch.raw_samples[i]);
            OP_CLEAR: if (in_ch.lane_mask[i]) evt_q[i] = 1'b0;
            OP_RESET: if (in_ch.lane_mask[i]) clear_lane(i);
            default: ;
          endcase
          if (!was_set && evt_q[i]) rise_tally++;
          view.states[2*i +: 2] = phase_q[i];
          view.flags[i]         = evt_q[i];
        end
        expected_views.push_back(view);
      end

      if (out_ch.valid && out_ch.ready) begin
        got.states = out_ch.lane_states;
        got.flags  = out_ch.event_flags;
        if (expected_views.size() == 0) begin
          $display("%0t: result transfer with nothing expected, lane_states %h event_flags %h",
                   $time, got.states, got.flags);
          fail_tally++;
        end else begin
          view = expected_views.pop_front();
          checked_tally++;
          for (int i = 0; i < LANES; i++) begin
            if (view.states[2*i +: 2] == PH_HELD) begin
              held_tally++;
              break;
            end
          end
          if (got.states !== view.states) begin
            $display("%0t: lane_states expected %h actual %h", $time, view.states, got.states);
            fail_tally++;
          end
          if (got.flags !== view.flags) begin
            $display("%0t: event_flags expected %h actual %h", $time, view.flags, got.flags);
            fail_tally++;
          end
        end
      end
    end
    mismatches      <= fail_tally;
    outstanding     <= expected_views.size();
    results_checked <= checked_tally;
    held_results    <= held_tally;
    event_rises     <= rise_tally;
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import bdhr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bdhr_in_if  in_ch ();
  bdhr_out_if out_ch ();

  int mismatches;
  int outstanding;
  int results_checked;
  int held_results;
  int event_rises;

  bit calm_sender;
  bit calm_receiver;
  int settings_used;
  bit leftover;

  bit btn_down[LANES];
  int btn_left[LANES];
  int btn_bounce[LANES];

  button_debounce_hold_repeat_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bdhr_lane_checker lane_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .held_results    (held_results),
    .event_rises     (event_rises)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [LANES-1:0] raw,
                         input logic [LANES-1:0] mask);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.raw_samples <= raw;
    in_ch.lane_mask   <= mask;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic next_raw(output logic [LANES-1:0] raw);
    int pick;
    for (int i = 0; i < LANES; i++) begin
      if (btn_left[i] == 0) begin
        btn_down[i] = !btn_down[i];
        pick = $urandom_range(0, 9);
        if (pick < 3) btn_left[i] = $urandom_range(1, 4);
        else if (pick < 8) btn_left[i] = $urandom_range(5, 40);
        else btn_left[i] = $urandom_range(41, 300);
        btn_bounce[i] = $urandom_range(0, 4);
      end
      if (btn_bounce[i] > 0) begin
        raw[i] = 1'($urandom_range(0, 1));
        btn_bounce[i]--;
      end else begin
        raw[i] = !btn_down[i];
      end
      btn_left[i]--;
    end
  endtask

  task automatic random_item();
    int               pick;
    logic [LANES-1:0] raw;
    logic [LANES-1:0] mask;
    pick = $urandom_range(0, 99);
    mask = LANES'($urandom_range(0, 15));
    if (pick < 85) begin
      next_raw(raw);
      if (pick < 8) raw = LANES'($urandom_range(0, 15));
      send_op(OP_TICK, raw, mask);
    end else if (pick < 92) begin
      send_op(OP_CLEAR, LANES'($urandom_range(0, 15)), mask);
    end else if (pick < 97) begin
      if ($urandom_range(0, 1)) mask = 4'b0001 << $urandom_range(0, 3);
      send_op(OP_RESET, LANES'($urandom_range(0, 15)), mask);
    end else begin
      send_op(OP_UNUSED, LANES'($urandom_range(0, 15)), mask);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    int taken;
    int gap;
    taken = 0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm_receiver ? 0 : $urandom_range(0, 8);
      if (taken == 150 || taken == 450 || taken == 620) gap = 80;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_TICK;
    in_ch.raw_samples = '1;
    in_ch.lane_mask   = '0;
    calm_sender       = 1'b0;
    calm_receiver     = 1'b0;
    settings_used     = 0;
    leftover          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Press every lane at the reset settings, then exercise clear, release and lane reset.
    repeat (5) send_op(OP_TICK, 4'b0000, 4'b1111);
    send_op(OP_UNUSED, 4'b1111, 4'b1111);
    send_op(OP_CLEAR, 4'b0000, 4'b0101);
    repeat (5) send_op(OP_TICK, 4'b1010, 4'b0000);
    send_op(OP_RESET, 4'b0101, 4'b0011);

    // With a zero threshold and period, lanes go held at once and repeat on every tick.
    drain(5000);
    write_reg(CFG_HOLD_THRESHOLD, '0);
    write_reg(CFG_REPEAT_PERIOD, '0);
    repeat (8) send_op(OP_TICK, 4'b0000, 4'b1010);
    send_op(OP_CLEAR, 4'b1111, 4'b1111);
    repeat (2) send_op(OP_TICK, 4'b1111, 4'b0101);

    for (int phase = 0; phase < 10; phase++) begin
      drain(5000);
      case (phase)
        0: begin
          write_reg(CFG_HOLD_THRESHOLD, HOLD_THRESHOLD_RST);
          write_reg(CFG_REPEAT_PERIOD, REPEAT_PERIOD_RST);
        end
        1: begin
          write_reg(CFG_HOLD_THRESHOLD, '1);
          write_reg(CFG_REPEAT_PERIOD, '1);
        end
        2: begin
          write_reg(CFG_HOLD_THRESHOLD, '0);
          write_reg(CFG_REPEAT_PERIOD, '1);
        end
        3: begin
          write_reg(CFG_HOLD_THRESHOLD, 8'd3);
          write_reg(CFG_REPEAT_PERIOD, '0);
        end
        default: begin
          if ($urandom_range(0, 3) != 0) write_reg(CFG_HOLD_THRESHOLD, pick_setting());
          if ($urandom_range(0, 3) != 0) write_reg(CFG_REPEAT_PERIOD, pick_setting());
        end
      endcase
      calm_sender   = (phase % 4 == 3);
      calm_receiver = (phase % 3 == 2);
      repeat (95) random_item();
    end

    drain(5000);
    repeat (4) @(posedge clk);
    if (outstanding != 0) begin
      $display("%0t: %0d expected results never arrived", $time, outstanding);
      leftover = 1'b1;
    end
    $display("Checked %0d result transfers across %0d register writes.",
             results_checked, settings_used);
    $display("%0d results showed a held lane and %0d lane events were raised.",
             held_results, event_rises);
    if (mismatches == 0 && !leftover) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bdhr_pkg.sv
hw/rtl/bdhr_in_if.sv
hw/rtl/bdhr_out_if.sv
hw/rtl/bdhr_cfg_regs.sv
hw/rtl/bdhr_lane.sv
hw/rtl/button_debounce_hold_repeat_core.sv
dv/bdhr_lane_checker.sv
dv/tb.sv
